/* src/midi_stream_parser_assert.svh */
// ----------------------------------------------------------------------------
// MIDI stream parser assertion macros
// Shared concurrent assertion forms for the parser's internal checks.
// ----------------------------------------------------------------------------
`ifndef MIDI_STREAM_PARSER_ASSERT_SVH
`define MIDI_STREAM_PARSER_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define MSP_ASSERT_NOW(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("midi_stream_parser: same-cycle check failed");

// Condition must hold in the cycle after the trigger.
`define MSP_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("midi_stream_parser: next-cycle check failed");

`endif

/* src/msp_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI stream parser package
// Types and constants shared by the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

   localparam logic [7:0]  STATUS_BIT    = 8'h80;
   localparam logic [7:0]  REALTIME_MASK = 8'hF8;
   localparam logic [7:0]  SYSEX_START   = 8'hF0;
   localparam logic [7:0]  SYSEX_END     = 8'hF7;
   localparam logic [7:0]  TUNE_SELECT   = 8'hF1;
   localparam logic [7:0]  SONG_POSITION = 8'hF2;
   localparam logic [7:0]  SONG_SELECT   = 8'hF3;
   localparam logic [15:0] LIMIT_RESET   = 16'd256;

   // Upper nibbles of channel voice status bytes.
   localparam logic [3:0] HI_NOTE_OFF    = 4'h8;
   localparam logic [3:0] HI_NOTE_ON     = 4'h9;
   localparam logic [3:0] HI_POLY_PRESS  = 4'hA;
   localparam logic [3:0] HI_CONTROL     = 4'hB;
   localparam logic [3:0] HI_PROGRAM     = 4'hC;
   localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;
   localparam logic [3:0] HI_PITCH_BEND  = 4'hE;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_FIRST  = 3'd1,
      MODE_SECOND = 3'd2,
      MODE_SYSEX  = 3'd3,
      MODE_SINGLE = 3'd4
   } parse_mode_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_REALTIME = 3'd1,
      EV_ONE      = 3'd2,
      EV_TWO      = 3'd3,
      EV_SX_BYTE  = 3'd4,
      EV_SX_END   = 3'd5
   } event_kind_type;

   typedef enum logic [1:0] {
      RC_OK        = 2'd0,
      RC_UNDEFINED = 2'd1,
      RC_OVERFLOW  = 2'd2
   } result_code_type;

   typedef struct packed {
      parse_mode_type mode;
      logic [7:0]     running_status;
      logic [6:0]     held_first_data;
      logic [15:0]    sysex_index;
   } parse_state_type;

   typedef struct packed {
      event_kind_type  event_kind;
      logic [7:0]      status_value;
      logic [6:0]      data_first;
      logic [6:0]      data_second;
      logic [15:0]     sysex_count;
      result_code_type result_code;
   } result_type;

endpackage

`default_nettype wire

/* src/msp_req_if.sv */
// ----------------------------------------------------------------------------
// MIDI stream parser request channel
// Valid/ready channel carrying one received byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface msp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       restart;

   modport source (output valid, output in_byte, output restart, input ready);
   modport sink   (input valid, input in_byte, input restart, output ready);
endinterface

`default_nettype wire

/* src/msp_rsp_if.sv */
// ----------------------------------------------------------------------------
// MIDI stream parser response channel
// Valid/ready channel carrying one parse result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface msp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [7:0]  status_value;
   logic [6:0]  data_first;
   logic [6:0]  data_second;
   logic [15:0] sysex_count;
   logic [1:0]  result_code;

   modport source (output valid, output event_kind, output status_value,
                   output data_first, output data_second, output sysex_count,
                   output result_code, input ready);
   modport sink   (input valid, input event_kind, input status_value,
                   input data_first, input data_second, input sysex_count,
                   input result_code, output ready);
endinterface

`default_nettype wire

/* src/midi_stream_parser.sv */
// ----------------------------------------------------------------------------
// MIDI stream parser
// Running-status parser for a received MIDI byte stream, one byte per beat.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   --------  ---------  ------------------------------------------------
//   req       in         in_byte, restart (one received byte per beat)
//   rsp       out        event_kind, status, data, sysex count, result code
//   csr       in         csr_we / csr_wdata: sysex length limit
//
// Every accepted byte gives exactly one result beat, through the input register
// and then the result register; a new byte can be taken in every cycle unless
// the result stalls, via the combinational decoder between the two registers.
// A stalled result holds the result register, which holds the input register,
// and req.ready drops for as long as both are full. Synchronous reset returns
// the parser to idle with a sysex limit of 256.
//
`default_nettype none

module midi_stream_parser
   import msp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   msp_req_if.sink          req,
   msp_rsp_if.source        rsp,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);

`include "midi_stream_parser_assert.svh"

   // Input register: holds the accepted beat until the decoder consumes it.
   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            restart_ff;

   // Parser state and the configured sysex limit.
   parse_state_type state_ff;
   parse_state_type state_in;
   logic [15:0]     limit_ff;

   // Result register feeding the response channel.
   logic            rsp_valid_ff;
   result_type      rsp_ff;
   result_type      rsp_in;

   // The decoder fires when a byte is waiting and the result register is
   // either empty or being emptied this cycle.
   logic            advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.in_byte;
         restart_ff <= req.restart;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   msp_decode u_decode (
      .cur_state   (state_ff),
      .in_byte     (in_byte_ff),
      .restart     (restart_ff),
      .sysex_limit (limit_ff),
      .nxt_state   (state_in),
      .result      (rsp_in)
   );

   // The parser state moves only when a byte passes through the decoder.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.event_kind   = rsp_ff.event_kind;
   assign rsp.status_value = rsp_ff.status_value;
   assign rsp.data_first   = rsp_ff.data_first;
   assign rsp.data_second  = rsp_ff.data_second;
   assign rsp.sysex_count  = rsp_ff.sysex_count;
   assign rsp.result_code  = rsp_ff.result_code;

   // A waiting byte that cannot advance must still be waiting next cycle.
   `MSP_ASSERT_NEXT(a_in_held, clock, reset, in_valid_ff && !advance, in_valid_ff)

   // Every decoded byte leaves a result beat behind it.
   `MSP_ASSERT_NEXT(a_rsp_loaded, clock, reset, advance, rsp_valid_ff)

   // An error result never carries an event.
   `MSP_ASSERT_NOW(a_err_no_event, clock, reset,
                   rsp_valid_ff && (rsp_ff.result_code != RC_OK),
                   rsp_ff.event_kind == EV_NONE)

   // Sysex bytes are only streamed under the sysex start status.
   `MSP_ASSERT_NOW(a_sysex_status, clock, reset,
                   rsp_valid_ff && (rsp_ff.event_kind == EV_SX_BYTE),
                   rsp_ff.status_value == SYSEX_START)

endmodule

`default_nettype wire

/* src/msp_decode.sv */
// ----------------------------------------------------------------------------
// MIDI stream parser decoder
// Combinational next-state and result logic for one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_decode
   import msp_pkg::*;
(
   input  wire parse_state_type cur_state,
   input  wire logic [7:0]      in_byte,
   input  wire logic            restart,
   input  wire logic [15:0]     sysex_limit,
   output parse_state_type      nxt_state,
   output result_type           result
);

   logic [3:0] hi_nibble;
   logic       is_single;
   logic       is_double;

   assign hi_nibble = in_byte[7:4];

   assign is_single = (hi_nibble == HI_PROGRAM) || (hi_nibble == HI_CHAN_PRESS) ||
                      (in_byte == TUNE_SELECT) || (in_byte == SONG_SELECT);
   assign is_double = (hi_nibble == HI_NOTE_OFF) || (hi_nibble == HI_NOTE_ON) ||
                      (hi_nibble == HI_POLY_PRESS) || (hi_nibble == HI_CONTROL) ||
                      (hi_nibble == HI_PITCH_BEND) || (in_byte == SONG_POSITION);

   always_comb begin
      nxt_state = cur_state;
      result    = '0;

      if (restart) begin
         nxt_state = '0;
      end else if ((in_byte & REALTIME_MASK) == REALTIME_MASK) begin
         result.event_kind   = EV_REALTIME;
         result.status_value = in_byte;
      end else if ((in_byte & STATUS_BIT) != 8'h00) begin
         if ((cur_state.mode == MODE_SYSEX) && (in_byte == SYSEX_END)) begin
            result.event_kind   = EV_SX_END;
            result.status_value = cur_state.running_status;
            result.sysex_count  = cur_state.sysex_index;
            nxt_state.mode      = MODE_IDLE;
         end else begin
            priority if (is_single) begin
               nxt_state.mode           = MODE_SINGLE;
               nxt_state.running_status = in_byte;
            end else if (is_double) begin
               nxt_state.mode           = MODE_FIRST;
               nxt_state.running_status = in_byte;
            end else if (in_byte == SYSEX_START) begin
               nxt_state.mode           = MODE_SYSEX;
               nxt_state.running_status = in_byte;
               nxt_state.sysex_index    = '0;
            end else begin
               // Undefined status, including an end of exclusive with no frame open.
               nxt_state.mode     = MODE_IDLE;
               result.result_code = RC_UNDEFINED;
            end
         end
      end else begin
         unique case (cur_state.mode)
            MODE_FIRST: begin
               nxt_state.held_first_data = in_byte[6:0];
               nxt_state.mode            = MODE_SECOND;
            end
            MODE_SECOND: begin
               result.event_kind         = EV_TWO;
               result.status_value       = cur_state.running_status;
               result.data_first         = cur_state.held_first_data;
               result.data_second        = in_byte[6:0];
               nxt_state.held_first_data = '0;
               nxt_state.mode            = MODE_FIRST;
            end
            MODE_SINGLE: begin
               result.event_kind   = EV_ONE;
               result.status_value = cur_state.running_status;
               result.data_first   = in_byte[6:0];
            end
            MODE_SYSEX: begin
               if (cur_state.sysex_index < sysex_limit) begin
                  result.event_kind     = EV_SX_BYTE;
                  result.status_value   = cur_state.running_status;
                  result.data_first     = in_byte[6:0];
                  result.sysex_count    = cur_state.sysex_index;
                  nxt_state.sysex_index = cur_state.sysex_index + 16'd1;
               end else begin
                  nxt_state.sysex_index = '0;
                  nxt_state.mode        = MODE_IDLE;
                  result.result_code    = RC_OVERFLOW;
               end
            end
            default: begin
               // Data byte with no message open is dropped.
               nxt_state.mode = MODE_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
